### hw/rtl/v2py_pkg.sv
`timescale 1ns / 1ps

package v2py_pkg;

  // Defaults for the top-level parameters.
  localparam int CORDIC_ITERS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;

  // Fixed datapath sizes that follow from the 32-bit input fields.
  localparam int IN_W       = 32;
  localparam int OUT_W      = 25;
  localparam int GUARD_BITS = 16;
  // Magnitudes reach 2^32 * 2^16 times the CORDIC gain, so 52 signed bits hold them.
  localparam int CORDIC_W   = 52;
  localparam int SQRT_STEPS = 32;
  localparam int ROM_DEPTH  = 32;

  // Output range limits in Q9.16.
  localparam logic signed [OUT_W-1:0] OUT_M91  = -25'sd5963776;
  localparam logic signed [OUT_W-1:0] OUT_P89  = 25'sd5832704;
  localparam logic signed [OUT_W-1:0] OUT_P180 = 25'sd11796480;

  // Whole degrees scaled to the internal angle format.
  function automatic longint deg_const(int d, int fb);
    return longint'(d) * (longint'(1) << fb);
  endfunction

  // Unsigned quotient and remainder by restoring shift and subtract.
  // The quotient is returned in the upper 64 bits, the remainder in the lower 64.
  function automatic logic [127:0] udivmod(longint unsigned n, longint unsigned d);
    longint unsigned q;
    logic [64:0]     r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return {q, r[63:0]};
  endfunction

  // atan(1/n) in radians with 56 fraction bits, by the arctangent series.
  function automatic longint atan_recip(longint unsigned n);
    longint unsigned p;
    longint unsigned n2;
    longint unsigned k;
    longint          sum;
    longint          t;
    logic [127:0]    dm;
    dm  = udivmod(64'd1 << 56, n);
    p   = dm[127:64];
    n2  = n * n;
    sum = 0;
    k   = 0;
    while (p != 0) begin
      dm  = udivmod(p, 2 * k + 1);
      t   = longint'(dm[127:64]);
      sum = k[0] ? sum - t : sum + t;
      dm  = udivmod(p, n2);
      p   = dm[127:64];
      k   = k + 1;
    end
    return sum;
  endfunction

  // atan(2^-i) in degrees, truncated to fb fraction bits.
  function automatic longint atan_deg(int i, int fb);
    longint unsigned qp;
    longint unsigned num;
    longint unsigned q;
    longint unsigned r;
    logic [127:0]    dm;
    if (i == 0) begin
      return deg_const(45, fb);
    end
    qp  = longint'(4 * atan_recip(64'd5) - atan_recip(64'd239));
    num = longint'(atan_recip(64'd1 << i)) * 45;
    dm  = udivmod(num, qp);
    q   = dm[127:64];
    r   = dm[63:0];
    for (int b = 0; b < fb; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= qp) begin
        r = r - qp;
        q = q | 64'd1;
      end
    end
    return longint'(q);
  endfunction

endpackage

### hw/rtl/v2py_in_if.sv
`timescale 1ns / 1ps

// Request channel: one direction vector.
interface v2py_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [v2py_pkg::IN_W-1:0]     dir_x;
  logic signed [v2py_pkg::IN_W-1:0]     dir_y;
  logic signed [v2py_pkg::IN_W-1:0]     dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

### hw/rtl/v2py_out_if.sv
`timescale 1ns / 1ps

// Result channel: pitch and yaw in Q9.16 degrees.
interface v2py_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [v2py_pkg::OUT_W-1:0]    pitch_deg;
  logic signed [v2py_pkg::OUT_W-1:0]    yaw_deg;

  modport source (output valid, output pitch_deg, output yaw_deg, input ready);
  modport sink   (input valid, input pitch_deg, input yaw_deg, output ready);
endinterface

### hw/rtl/vector_to_pitch_yaw_core.sv
`timescale 1ns / 1ps
// Pipeline: a request passes the input, magnitude, square and sum registers, 32 square-root
// digit stages, min(CORDIC_ITERS, ROM_DEPTH) pitch stages, fold/wrap and result registers.
// Throughput: one request per cycle; the whole pipeline advances whenever the result
// register is empty or is being taken.
// Reset: rst_ni is asynchronous and active low; it clears every valid bit.

module vector_to_pitch_yaw_core #(
  parameter int CORDIC_ITERS = v2py_pkg::CORDIC_ITERS_DEF,
  parameter int FRAC_BITS    = v2py_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  v2py_in_if.sink    req_i,
  v2py_out_if.source res_o
);

  localparam int NIT   = (CORDIC_ITERS > v2py_pkg::ROM_DEPTH) ? v2py_pkg::ROM_DEPTH
                                                               : CORDIC_ITERS;
  localparam int AW    = FRAC_BITS + 11;
  localparam int CW    = v2py_pkg::CORDIC_W;
  localparam int IW    = v2py_pkg::IN_W;
  localparam int OW    = v2py_pkg::OUT_W;
  localparam int GB    = v2py_pkg::GUARD_BITS;
  localparam int NSQ   = v2py_pkg::SQRT_STEPS;

  localparam logic signed [AW-1:0] D89  = AW'(v2py_pkg::deg_const(89, FRAC_BITS));
  localparam logic signed [AW-1:0] D90  = AW'(v2py_pkg::deg_const(90, FRAC_BITS));
  localparam logic signed [AW-1:0] D91  = AW'(v2py_pkg::deg_const(91, FRAC_BITS));
  localparam logic signed [AW-1:0] D180 = AW'(v2py_pkg::deg_const(180, FRAC_BITS));
  localparam logic signed [AW-1:0] D270 = AW'(v2py_pkg::deg_const(270, FRAC_BITS));
  localparam logic signed [AW-1:0] D360 = AW'(v2py_pkg::deg_const(360, FRAC_BITS));

  logic en;

  // The pipeline moves as a whole when the result register can take a new value.
  logic out_v_q;
  assign en          = !out_v_q || res_o.ready;
  assign req_i.ready = en;

  // Stage 1: request register.
  logic                 s1_v_q;
  logic signed [IW-1:0] s1_x_q, s1_y_q, s1_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q <= req_i.dir_x;
      s1_y_q <= req_i.dir_y;
      s1_z_q <= req_i.dir_z;
    end
  end

  // Stage 2: magnitudes of x and y, and the on-axis flag.
  logic                 s2_v_q, s2_zero_q;
  logic        [IW-1:0] s2_ax_q, s2_ay_q;
  logic signed [IW-1:0] s2_x_q, s2_y_q, s2_z_q;
  logic signed [IW:0]   s2_xw, s2_yw;

  assign s2_xw = (IW+1)'(s1_x_q);
  assign s2_yw = (IW+1)'(s1_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ax_q   <= (s1_x_q < 0) ? IW'(-s2_xw) : IW'(s2_xw);
      s2_ay_q   <= (s1_y_q < 0) ? IW'(-s2_yw) : IW'(s2_yw);
      s2_zero_q <= (s1_x_q == '0) && (s1_y_q == '0);
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_z_q    <= s1_z_q;
    end
  end

  // Stage 3: squares of the magnitudes.
  logic                 s3_v_q, s3_zero_q;
  logic        [63:0]   s3_sqx_q, s3_sqy_q;
  logic signed [IW-1:0] s3_x_q, s3_y_q, s3_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sqx_q  <= 64'(s2_ax_q) * 64'(s2_ax_q);
      s3_sqy_q  <= 64'(s2_ay_q) * 64'(s2_ay_q);
      s3_zero_q <= s2_zero_q;
      s3_x_q    <= s2_x_q;
      s3_y_q    <= s2_y_q;
      s3_z_q    <= s2_z_q;
    end
  end

  // Stage 4: sum of squares, and the yaw vector folded into the right half plane.
  logic                 sq_v_q    [NSQ+1];
  logic                 sq_zero_q [NSQ+1];
  logic        [63:0]   sq_rem_q  [NSQ+1];
  logic        [63:0]   sq_res_q  [NSQ+1];
  logic signed [IW-1:0] sq_z_q    [NSQ+1];
  logic signed [CW-1:0] yx_q      [NSQ+1];
  logic signed [CW-1:0] yy_q      [NSQ+1];
  logic signed [AW-1:0] ya_q      [NSQ+1];

  logic signed [CW-1:0] s4_xe, s4_ye;

  assign s4_xe = CW'(s3_x_q);
  assign s4_ye = CW'(s3_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= s3_sqx_q + s3_sqy_q;
      sq_res_q[0]  <= '0;
      sq_zero_q[0] <= s3_zero_q;
      sq_z_q[0]    <= s3_z_q;
      if (s3_x_q < 0) begin
        yx_q[0] <= (-s4_xe) <<< GB;
        yy_q[0] <= (-s4_ye) <<< GB;
        ya_q[0] <= (s3_y_q >= 0) ? D180 : -D180;
      end else begin
        yx_q[0] <= s4_xe <<< GB;
        yy_q[0] <= s4_ye <<< GB;
        ya_q[0] <= '0;
      end
    end
  end

  // Square-root digit stages; the yaw CORDIC runs alongside in the first NIT of them.
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [63:0]          BIT = 64'd1 << (62 - 2 * k);
    localparam logic signed [AW-1:0] ANG = AW'(v2py_pkg::atan_deg(k, FRAC_BITS));
    localparam bit                   ROT = (k < NIT);

    logic        [64:0]   trial;
    logic        [63:0]   rem_d, res_d;
    logic signed [CW-1:0] x_d, y_d;
    logic signed [AW-1:0] a_d;

    always_comb begin
      trial = {1'b0, sq_res_q[k]} + {1'b0, BIT};
      if ({1'b0, sq_rem_q[k]} >= trial) begin
        rem_d = sq_rem_q[k] - trial[63:0];
        res_d = (sq_res_q[k] >> 1) + BIT;
      end else begin
        rem_d = sq_rem_q[k];
        res_d = sq_res_q[k] >> 1;
      end
    end

    // Vectoring step: drive y toward zero and collect the angle.
    always_comb begin
      x_d = yx_q[k];
      y_d = yy_q[k];
      a_d = ya_q[k];
      if (ROT) begin
        if (yy_q[k] >= 0) begin
          x_d = yx_q[k] + (yy_q[k] >>> k);
          y_d = yy_q[k] - (yx_q[k] >>> k);
          a_d = ya_q[k] + ANG;
        end else begin
          x_d = yx_q[k] - (yy_q[k] >>> k);
          y_d = yy_q[k] + (yx_q[k] >>> k);
          a_d = ya_q[k] - ANG;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k+1]  <= rem_d;
        sq_res_q[k+1]  <= res_d;
        sq_zero_q[k+1] <= sq_zero_q[k];
        sq_z_q[k+1]    <= sq_z_q[k];
        yx_q[k+1]      <= x_d;
        yy_q[k+1]      <= y_d;
        ya_q[k+1]      <= a_d;
      end
    end
  end

  // Pitch vector (r, -z); r is never negative, so no half-plane fold is needed.
  logic                 pv_q    [NIT+1];
  logic                 pzero_q [NIT+1];
  logic                 pzpos_q [NIT+1];
  logic signed [CW-1:0] px_q    [NIT+1];
  logic signed [CW-1:0] py_q    [NIT+1];
  logic signed [AW-1:0] pa_q    [NIT+1];
  logic signed [AW-1:0] pyaw_q  [NIT+1];

  logic signed [CW-1:0] pre_r, pre_z;

  assign pre_r = $signed(CW'(sq_res_q[NSQ]));
  assign pre_z = CW'(sq_z_q[NSQ]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else if (en) begin
      pv_q[0] <= sq_v_q[NSQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q[0]    <= pre_r <<< GB;
      py_q[0]    <= (-pre_z) <<< GB;
      pa_q[0]    <= '0;
      pzero_q[0] <= sq_zero_q[NSQ];
      pzpos_q[0] <= (sq_z_q[NSQ] > 0);
      pyaw_q[0]  <= (ya_q[NSQ] < 0) ? ya_q[NSQ] + D360 : ya_q[NSQ];
    end
  end

  // Pitch CORDIC stages.
  for (genvar i = 0; i < NIT; i++) begin : g_pitch
    localparam logic signed [AW-1:0] ANG = AW'(v2py_pkg::atan_deg(i, FRAC_BITS));

    logic signed [CW-1:0] x_d, y_d;
    logic signed [AW-1:0] a_d;

    always_comb begin
      if (py_q[i] >= 0) begin
        x_d = px_q[i] + (py_q[i] >>> i);
        y_d = py_q[i] - (px_q[i] >>> i);
        a_d = pa_q[i] + ANG;
      end else begin
        x_d = px_q[i] - (py_q[i] >>> i);
        y_d = py_q[i] + (px_q[i] >>> i);
        a_d = pa_q[i] - ANG;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[i+1] <= 1'b0;
      end else if (en) begin
        pv_q[i+1] <= pv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        px_q[i+1]    <= x_d;
        py_q[i+1]    <= y_d;
        pa_q[i+1]    <= a_d;
        pzero_q[i+1] <= pzero_q[i];
        pzpos_q[i+1] <= pzpos_q[i];
        pyaw_q[i+1]  <= pyaw_q[i];
      end
    end
  end

  // Fold and wrap stages: f raises pitch or picks the on-axis angles, g1/g2 fold
  // pitch into [-91, 89], h1/h2 wrap yaw. Both angles start non-negative, so the
  // upward folds of pitch and yaw never apply.
  logic                 f_v_q, g1_v_q, g2_v_q, h1_v_q, h2_v_q;
  logic signed [AW-1:0] f_p_q, f_y_q, g1_p_q, g1_y_q, g2_p_q, g2_y_q;
  logic signed [AW-1:0] h1_p_q, h1_y_q, h2_p_q, h2_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q  <= 1'b0;
      g1_v_q <= 1'b0;
      g2_v_q <= 1'b0;
      h1_v_q <= 1'b0;
      h2_v_q <= 1'b0;
    end else if (en) begin
      f_v_q  <= pv_q[NIT];
      g1_v_q <= f_v_q;
      g2_v_q <= g1_v_q;
      h1_v_q <= g2_v_q;
      h2_v_q <= h1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pzero_q[NIT]) begin
        f_p_q <= pzpos_q[NIT] ? D270 : D90;
        f_y_q <= '0;
      end else begin
        f_p_q <= (pa_q[NIT] < 0) ? pa_q[NIT] + D360 : pa_q[NIT];
        f_y_q <= pyaw_q[NIT];
      end
      g1_p_q <= (f_p_q > D89) ? f_p_q - D180 : f_p_q;
      g1_y_q <= (f_p_q > D89) ? f_y_q + D180 : f_y_q;
      g2_p_q <= (g1_p_q > D89) ? g1_p_q - D180 : g1_p_q;
      g2_y_q <= (g1_p_q > D89) ? g1_y_q + D180 : g1_y_q;
      h1_p_q <= g2_p_q;
      h1_y_q <= (g2_y_q > D180) ? g2_y_q - D360 : g2_y_q;
      h2_p_q <= h1_p_q;
      h2_y_q <= (h1_y_q > D180) ? h1_y_q - D360 : h1_y_q;
    end
  end

  // Conversion to Q9.16: round half up when narrowing, exact shift when widening.
  logic signed [OW-1:0] q16_p, q16_y;

  if (FRAC_BITS > 16) begin : g_narrow
    localparam int S = FRAC_BITS - 16;
    localparam logic signed [AW:0] HALF = (AW+1)'(1) <<< (S - 1);
    logic signed [AW:0] rp, ry;
    assign rp    = ((AW+1)'(h2_p_q) + HALF) >>> S;
    assign ry    = ((AW+1)'(h2_y_q) + HALF) >>> S;
    assign q16_p = rp[OW-1:0];
    assign q16_y = ry[OW-1:0];
  end else begin : g_widen
    localparam int S = 16 - FRAC_BITS;
    logic signed [AW+S-1:0] wp, wy;
    assign wp    = (AW+S)'(h2_p_q) <<< S;
    assign wy    = (AW+S)'(h2_y_q) <<< S;
    assign q16_p = wp[OW-1:0];
    assign q16_y = wy[OW-1:0];
  end

  // Result register.
  logic signed [OW-1:0] out_p_q, out_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= h2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_p_q <= q16_p;
      out_y_q <= q16_y;
    end
  end

  assign res_o.valid     = out_v_q;
  assign res_o.pitch_deg = out_p_q;
  assign res_o.yaw_deg   = out_y_q;

`ifndef SYNTHESIS
  // Pitch folding leaves the angle inside [-91, 89] degrees.
  a_fold_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g2_v_q |-> (g2_p_q <= D89 && g2_p_q >= -D91))
    else $error("pitch out of range after folding");

  // Yaw wrapping leaves the angle inside [-180, 180] degrees.
  a_wrap_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h2_v_q |-> (h2_y_q <= D180 && h2_y_q >= -D180))
    else $error("yaw out of range after wrapping");

  // The rounded pitch result stays within its documented range.
  a_out_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_p_q >= v2py_pkg::OUT_M91 && out_p_q <= v2py_pkg::OUT_P89))
    else $error("pitch result out of range");

  // The rounded yaw result stays within its documented range.
  a_out_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_y_q >= -v2py_pkg::OUT_P180 && out_y_q <= v2py_pkg::OUT_P180))
    else $error("yaw result out of range");
`endif

endmodule

### dv/tb_vector_to_pitch_yaw_checker.sv
`timescale 1ns / 1ps

module tb_vector_to_pitch_yaw_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  v2py_in_if.sink             req_i,
  v2py_out_if.sink            res_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  seen_o
);

  localparam int FB    = v2py_pkg::FRAC_BITS_DEF;
  localparam int RD    = v2py_pkg::ROM_DEPTH;
  localparam int GB    = v2py_pkg::GUARD_BITS;
  localparam int OW    = v2py_pkg::OUT_W;
  localparam int ITERS = (v2py_pkg::CORDIC_ITERS_DEF > RD) ? RD : v2py_pkg::CORDIC_ITERS_DEF;

  typedef struct packed {
    logic signed [OW-1:0] pitch;
    logic signed [OW-1:0] yaw;
  } angles_t;

  longint  atan_tab[RD];
  angles_t angle_q[$];
  int      fails;
  int      seen;

  assign fail_cnt_o = fails;
  assign pending_o  = angle_q.size();
  assign seen_o     = seen;

  // The arctangent table is rebuilt here with the same integer series.
  function automatic longint series_atan(longint unsigned n);
    longint unsigned p, n2, k;
    longint          acc, t;
    p   = (64'd1 << 56) / n;
    n2  = n * n;
    acc = 0;
    k   = 0;
    while (p != 0) begin
      t   = longint'(p / (2 * k + 1));
      acc = k[0] ? acc - t : acc + t;
      p   = p / n2;
      k++;
    end
    return acc;
  endfunction

  initial begin
    longint unsigned qp, num, q, r;
    atan_tab[0] = longint'(45) <<< FB;
    qp = longint'(4 * series_atan(64'd5) - series_atan(64'd239));
    for (int i = 1; i < RD; i++) begin
      num = longint'(series_atan(64'd1 << i)) * 45;
      q   = num / qp;
      r   = num % qp;
      for (int b = 0; b < FB; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= qp) begin
          r = r - qp;
          q = q | 64'd1;
        end
      end
      atan_tab[i] = longint'(q);
    end
  end

  // Vectoring-mode CORDIC; the shift operator on signed longint floors.
  function automatic longint vec_angle(longint yy, longint xx);
    longint a, xs, ys;
    a = 0;
    if (xx < 0) begin
      a  = (yy >= 0) ? (longint'(180) <<< FB) : -(longint'(180) <<< FB);
      xx = -xx;
      yy = -yy;
    end
    xx = xx <<< GB;
    yy = yy <<< GB;
    for (int i = 0; i < ITERS; i++) begin
      xs = xx >>> i;
      ys = yy >>> i;
      if (yy >= 0) begin
        xx += ys;
        yy -= xs;
        a  += atan_tab[i];
      end else begin
        xx -= ys;
        yy += xs;
        a  -= atan_tab[i];
      end
    end
    return a;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint to_q16(longint v);
    if (FB > 16) return (v + (longint'(1) << (FB - 17))) >>> (FB - 16);
    return v <<< (16 - FB);
  endfunction

  // Pitch and yaw of one direction vector, folded as the block does.
  function automatic angles_t predict_angles(longint x, longint y, longint z);
    longint          p, w, one;
    longint unsigned ax, ay;
    angles_t         o;
    one = longint'(1) <<< FB;
    if (x == 0 && y == 0) begin
      w = 0;
      p = (z > 0) ? 270 * one : 90 * one;
    end else begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      w  = vec_angle(y, x);
      if (w < 0) w += 360 * one;
      p = vec_angle(-z, longint'(int_sqrt(ax * ax + ay * ay)));
      if (p < 0) p += 360 * one;
    end
    while (p < -89 * one) begin
      p += 180 * one;
      w += 180 * one;
    end
    while (p > 89 * one) begin
      p -= 180 * one;
      w += 180 * one;
    end
    while (w < -180 * one) w += 360 * one;
    while (w > 180 * one) w -= 360 * one;
    o.pitch = OW'(to_q16(p));
    o.yaw   = OW'(to_q16(w));
    return o;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  // Predict on each accepted request and compare each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    angles_t e;
    if (!rst_ni) begin
      fails = 0;
      seen  = 0;
      angle_q.delete();
    end else begin
      if (req_i.valid && req_i.ready)
        angle_q.push_back(predict_angles(req_i.dir_x, req_i.dir_y, req_i.dir_z));
      if (res_i.valid && res_i.ready) begin
        seen++;
        if (angle_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          e = angle_q.pop_front();
          if (res_i.pitch_deg !== e.pitch) report("pitch_deg", res_i.pitch_deg, e.pitch);
          if (res_i.yaw_deg !== e.yaw) report("yaw_deg", res_i.yaw_deg, e.yaw);
        end
      end
    end
  end
endmodule

### dv/tb_vector_to_pitch_yaw_core.sv
`timescale 1ns / 1ps

module tb_vector_to_pitch_yaw_core;
  localparam int N_RANDOM  = 1700;
  localparam int LIMIT     = 400000;
  localparam int LATENCY   = 42 + v2py_pkg::CORDIC_ITERS_DEF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending, seen, cycles, sent;
  bit   calm;
  bit   hold_long;

  v2py_in_if  req_if ();
  v2py_out_if res_if ();

  always #1 clk_i = ~clk_i;

  vector_to_pitch_yaw_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .res_o  (res_if.source)
  );

  tb_vector_to_pitch_yaw_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if.sink),
    .res_i      (res_if.sink),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .seen_o     (seen)
  );

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_vector_to_pitch_yaw_core: FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off, none at the end.
  initial begin
    int n;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        res_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_long = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        res_if.ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0;
      3:       return $urandom_range(0, 8) - 4;
      4:       return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Send one request, with an occasional random idle burst in front of it.
  task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.dir_x <= x;
    req_if.dir_y <= y;
    req_if.dir_z <= z;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
  endtask

  initial begin
    logic [31:0] corner[5];
    int          wait_n;
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 32'hFFFF_0000};
    req_if.valid = 1'b0;
    req_if.dir_x = '0;
    req_if.dir_y = '0;
    req_if.dir_z = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: vertical vectors, exact axes, the most negative and most positive values, and corner mixes.
    send_vec(0, 0, 0);
    send_vec(0, 0, 32'h0001_0000);
    send_vec(0, 0, 32'hFFFF_0000);
    send_vec(32'h0001_0000, 0, 0);
    send_vec(32'hFFFF_0000, 0, 0);
    send_vec(0, 32'h0001_0000, 0);
    send_vec(0, 32'hFFFF_0000, 0);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vec(32'h8000_0000, 0, 32'h7FFF_FFFF);
    for (int i = 0; i < 12; i++)
      send_vec(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)],
               corner[$urandom_range(0, 4)]);

    // Random vectors; a long receiver hold-off partway through fills the pipe.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 400) hold_long = 1;
      if (i == N_RANDOM - 200) calm = 1;
      send_vec(rand_coord(), rand_coord(), rand_coord());
    end
    req_if.valid <= 1'b0;

    wait_n = 0;
    while (pending != 0 && wait_n < 20000) begin
      @(posedge clk_i);
      wait_n++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("sent %0d vectors (vertical, axis, extreme and random), checked %0d results",
             sent, seen);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_vector_to_pitch_yaw_core: PASS");
    end else begin
      $display("tb_vector_to_pitch_yaw_core: FAIL");
    end
    $finish;
  end
endmodule
